// ----- src/rsc_pkg.sv -----
`timescale 1ns / 1ps

package rsc_pkg;

  localparam int ACC_WIDTH  = 64;
  localparam int MAX_DIGITS = 64;

  // Bits of dividend retired per divider cycle, and the padded dividend width
  localparam int RADIX_BITS = 8;
  localparam int DIV_STEPS  = (ACC_WIDTH + RADIX_BITS - 1) / RADIX_BITS;
  localparam int QUO_WIDTH  = DIV_STEPS * RADIX_BITS;

  localparam int ADDR_W = $clog2(MAX_DIGITS);
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int STEP_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int BASE_W = 6;

  // Character offsets
  localparam logic [7:0] NUM_ZERO      = 8'(600 - 552);
  localparam logic [7:0] LOWER_OFS     = 8'(466 - 379);
  localparam logic [7:0] UPPER_OFS     = 8'(322 - 267);
  localparam logic [6:0] OUT_NUM_OFS   = 7'(262 - 214);
  localparam logic [6:0] OUT_ALPHA_OFS = 7'(771 - 716);

  // Register indexes and reset values
  localparam logic REG_SOURCE_BASE = 1'b0;
  localparam logic REG_TARGET_BASE = 1'b1;
  localparam logic [BASE_W-1:0] SOURCE_BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] TARGET_BASE_RESET = 6'd16;
  localparam logic [BASE_W-1:0] TB_MIN = 6'd2;
  localparam logic [BASE_W-1:0] TB_MAX = 6'd36;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       out_last;
  } out_beat_t;

endpackage

// ----- src/rsc_ram.sv -----
`timescale 1ns / 1ps

module rsc_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/radix_string_converter_unit.sv -----
`timescale 1ns / 1ps

// Radix string converter.
// Input channel (in_valid / in_stall / in_beat): one character beat per
// number digit, most significant first, in_last on the final character.
// Each character is folded into the accumulator as it is taken, so
// characters that are not last are taken back to back and give no output.
// On the last character the block stops taking beats (in_stall high) and
// runs its shared divider: a compare-subtract unit that retires RADIX_BITS
// dividend bits a cycle. Remainders are pushed onto the digit stack RAM.
// Output channel (out_valid / out_stall / out_beat): digits leave most
// significant first as '0'-'9', 'A'-'Z', out_last on the final one. Each
// digit takes a stack read (S_RD, S_WAIT) and then loads the output
// register, which offers it in S_HOLD.
// A stalled output beat is held unchanged until taken; the block waits.
// Reset (rst, synchronous) clears the accumulator, bases go to 10 and 16,
// and the block is at once ready for a character. The stack needs no clear.
// APB: source_base at 0x0, target_base at 0x4; write only when idle.
module radix_string_converter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rsc_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  input  logic               out_stall,
  output rsc_pkg::out_beat_t out_beat,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import rsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;  // take characters
  localparam logic [2:0] S_DIV  = 3'd1;  // divider running
  localparam logic [2:0] S_RD   = 3'd2;  // issue stack read
  localparam logic [2:0] S_WAIT = 3'd3;  // stack data arrives
  localparam logic [2:0] S_HOLD = 3'd4;  // output beat on offer

  logic [2:0] state;

  logic [BASE_W-1:0] source_base;
  logic [BASE_W-1:0] target_base;

  logic [ACC_WIDTH-1:0] acc;
  logic [ACC_WIDTH-1:0] acc_next;
  logic [7:0]           digit_val;

  logic [QUO_WIDTH-1:0] quo;
  logic [QUO_WIDTH-1:0] quo_next;
  logic [BASE_W-1:0]    rem;
  logic [BASE_W-1:0]    rem_next;
  logic [BASE_W:0]      trial;
  logic [BASE_W-1:0]    tb;
  logic [STEP_W-1:0]    step;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_dec;

  logic              push;
  logic [ADDR_W-1:0] raddr;
  logic [5:0]        rdata;

  logic in_take;
  logic out_take;
  logic cfg_write;

  // ---------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= SOURCE_BASE_RESET;
      target_base <= TARGET_BASE_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_SOURCE_BASE: source_base <= pwdata[BASE_W-1:0];
        REG_TARGET_BASE: target_base <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SOURCE_BASE: prdata = {{(32-BASE_W){1'b0}}, source_base};
      REG_TARGET_BASE: prdata = {{(32-BASE_W){1'b0}}, target_base};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Character mapping and multiply-add
  // ---------------------------------------------------------------
  always_comb begin
    if (in_beat.in_char >= "0" && in_beat.in_char <= "9") begin
      digit_val = in_beat.in_char - NUM_ZERO;
    end else if (in_beat.in_char >= "a" && in_beat.in_char <= "z") begin
      digit_val = in_beat.in_char - LOWER_OFS;
    end else if (in_beat.in_char >= "A" && in_beat.in_char <= "Z") begin
      digit_val = in_beat.in_char - UPPER_OFS;
    end else begin
      digit_val = in_beat.in_char;  // keep the raw code
    end
  end

  // Wraps at the accumulator width by truncation
  assign acc_next = ACC_WIDTH'(acc * ACC_WIDTH'(source_base)) + ACC_WIDTH'(digit_val);

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // ---------------------------------------------------------------
  // Shared divider: RADIX_BITS restoring steps on a narrow remainder
  // ---------------------------------------------------------------
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    trial    = '0;
    for (int i = 0; i < RADIX_BITS; i++) begin
      trial    = {rem_next, quo_next[QUO_WIDTH-1]};
      quo_next = {quo_next[QUO_WIDTH-2:0], 1'b0};
      if (trial >= {1'b0, tb}) begin
        rem_next    = BASE_W'(trial - {1'b0, tb});
        quo_next[0] = 1'b1;
      end else begin
        rem_next = trial[BASE_W-1:0];
      end
    end
  end

  assign push      = (state == S_DIV) && (step == STEP_W'(DIV_STEPS - 1));
  assign count_dec = count - CNT_W'(1);
  assign raddr     = count_dec[ADDR_W-1:0];

  rsc_ram #(
    .WIDTH (6),
    .DEPTH (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (count[ADDR_W-1:0]),
    .wdata (rem_next),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      acc       <= '0;
      count     <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (in_beat.in_last) begin
              // Hand the value to the divider and clamp the target base
              acc   <= '0;
              quo   <= QUO_WIDTH'(acc_next);
              rem   <= '0;
              step  <= '0;
              count <= '0;
              if (target_base < TB_MIN) begin
                tb <= TB_MIN;
              end else if (target_base > TB_MAX) begin
                tb <= TB_MAX;
              end else begin
                tb <= target_base;
              end
              state <= S_DIV;
            end else begin
              acc <= acc_next;
            end
          end
        end
        S_DIV: begin
          if (push) begin
            // Digit done: push it, then stop on zero quotient or full stack
            count <= count + CNT_W'(1);
            quo   <= quo_next;
            rem   <= '0;
            step  <= '0;
            if (quo_next == '0 || count + CNT_W'(1) == CNT_W'(MAX_DIGITS)) begin
              state <= S_RD;
            end
          end else begin
            quo  <= quo_next;
            rem  <= rem_next;
            step <= step + STEP_W'(1);
          end
        end
        S_RD: begin
          count <= count_dec;
          state <= S_WAIT;
        end
        S_WAIT: begin
          out_beat.out_char <= (rdata <= 6'd9) ? OUT_NUM_OFS + 7'(rdata)
                                               : OUT_ALPHA_OFS + 7'(rdata);
          out_beat.out_last <= (count == '0);
          out_valid         <= 1'b1;
          state             <= S_HOLD;
        end
        S_HOLD: begin
          // Hold the beat until the receiver takes it
          if (out_take) begin
            out_valid <= 1'b0;
            state     <= out_beat.out_last ? S_IDLE : S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
